### src/tbc_pkg.sv
`timescale 1ns / 1ps
// Package for the triangle barycentric coordinates core.
// Holds shared widths, latencies, payload types and Q16.16 limits; no dependencies.
package tbc_pkg;

    localparam int CW = 16;              // input coordinate width
    localparam int EW = CW + 1;          // edge vector component width
    localparam int PW = 2 * EW;          // edge component product width
    localparam int DW = PW + 2;          // dot product width (sum of three)
    localparam int MW = 2 * DW;          // dot product pair product width
    localparam int OW = 32;              // Q16.16 weight width
    localparam int FB = 16;              // fraction bits of a weight
    localparam int QB = OW + 1;          // quotient bits resolved by the divider
    localparam int RW = MW + QB;         // divider remainder width

    localparam int MUL_LAT    = 2;
    localparam int DIV_LAT    = QB + 4;
    localparam int FRONT_LAT  = 4 + MUL_LAT;
    localparam int PIPE_DEPTH = FRONT_LAT + DIV_LAT;

    localparam int ONE_Q = 1 << FB;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [DW-1:0] dot_t;
    typedef logic signed [MW-1:0] wide_t;
    typedef logic signed [OW-1:0] weight_t;

    localparam weight_t W_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam weight_t W_MIN = {1'b1, {(OW-1){1'b0}}};

    typedef struct packed {
        weight_t u;
        weight_t v;
        weight_t w;
        logic    degenerate;
    } res_t;

endpackage

### src/tbc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the barycentric core: query in, weights out.
// Depends on tbc_pkg for payload types.
interface tbc_query_if;
    logic            valid;
    logic            ready;
    tbc_pkg::coord_t vertex_a_x;
    tbc_pkg::coord_t vertex_a_y;
    tbc_pkg::coord_t vertex_a_z;
    tbc_pkg::coord_t vertex_b_x;
    tbc_pkg::coord_t vertex_b_y;
    tbc_pkg::coord_t vertex_b_z;
    tbc_pkg::coord_t vertex_c_x;
    tbc_pkg::coord_t vertex_c_y;
    tbc_pkg::coord_t vertex_c_z;
    tbc_pkg::coord_t point_x;
    tbc_pkg::coord_t point_y;
    tbc_pkg::coord_t point_z;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, point_x, point_y, point_z,
        output ready
    );
endinterface

interface tbc_result_if;
    logic             valid;
    logic             ready;
    tbc_pkg::weight_t weight_u;
    tbc_pkg::weight_t weight_v;
    tbc_pkg::weight_t weight_w;
    logic             degenerate;

    modport source (
        output valid, weight_u, weight_v, weight_w, degenerate,
        input  ready
    );
    modport sink (
        input  valid, weight_u, weight_v, weight_w, degenerate,
        output ready
    );
endinterface

### src/tbc_smul.sv
`timescale 1ns / 1ps
// Two-stage signed multiplier for dot product pairs, built from four partial products.
// Depends on tbc_pkg.
module tbc_smul (
    input  logic          clk,
    input  logic          en,
    input  tbc_pkg::dot_t a,
    input  tbc_pkg::dot_t b,
    output tbc_pkg::wide_t p
);
    import tbc_pkg::*;

    localparam int HW = DW / 2;

    logic signed [HW-1:0]   a_hi, b_hi;
    logic        [HW-1:0]   a_lo, b_lo;
    logic signed [2*HW-1:0] hh_next, hh_reg;
    logic signed [2*HW:0]   hl_next, hl_reg, lh_next, lh_reg;
    logic        [2*HW-1:0] ll_next, ll_reg;
    wide_t                  p_next, p_reg;

    assign a_hi = a[DW-1:HW];
    assign b_hi = b[DW-1:HW];
    assign a_lo = a[HW-1:0];
    assign b_lo = b[HW-1:0];

    assign hh_next = a_hi * b_hi;
    assign hl_next = a_hi * $signed({1'b0, b_lo});
    assign lh_next = $signed({1'b0, a_lo}) * b_hi;
    assign ll_next = a_lo * b_lo;

    assign p_next = (MW'(hh_reg) <<< (2 * HW)) + (MW'(hl_reg) <<< HW)
                  + (MW'(lh_reg) <<< HW) + MW'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### src/tbc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: rounded, saturated Q16.16 of num / den, one quotient
// bit per stage. den must be positive. Depends on tbc_pkg.
module tbc_div (
    input  logic             clk,
    input  logic             en,
    input  tbc_pkg::wide_t   num,
    input  tbc_pkg::wide_t   den,
    output tbc_pkg::weight_t quo
);
    import tbc_pkg::*;

    localparam logic [QB:0] LIM_POS = (QB+1)'({1'b0, {(OW-1){1'b1}}});
    localparam logic [QB:0] LIM_NEG = (QB+1)'({1'b1, {(OW-1){1'b0}}});

    // magnitude stage
    logic          neg_a_reg;
    logic [MW-1:0] mag_next, mag_a_reg, den_a_reg;

    // overflow check stage feeds the bit steps
    logic [RW-1:0] nsh, dlim;
    logic          ovf_next;

    logic [RW-1:0] rem_reg [0:QB];
    logic [MW-1:0] dq_reg  [0:QB];
    logic          neg_reg [0:QB];
    logic          ovf_reg [0:QB];
    logic [QB-1:0] q_reg   [1:QB];

    // rounding and saturation
    logic          rnd;
    logic [QB:0]   qf_next, qf_reg;
    logic          negc_reg, ovfc_reg;
    logic          over;
    logic [OW-1:0] qlo;
    weight_t       quo_next, quo_reg;

    assign mag_next = num[MW-1] ? MW'(-num) : MW'(num);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= num[MW-1];
            mag_a_reg <= mag_next;
            den_a_reg <= den;
        end
    end

    assign nsh      = RW'({mag_a_reg, {FB{1'b0}}});
    assign dlim     = RW'(den_a_reg) << QB;
    assign ovf_next = nsh >= dlim;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= nsh;
            dq_reg[0]  <= den_a_reg;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        localparam int SH = QB - 1 - i;
        logic [RW-1:0] dsh;
        logic          take;
        logic [RW-1:0] rem_next;
        logic [QB-1:0] q_next;

        assign dsh      = RW'(dq_reg[i]) << SH;
        assign take     = rem_reg[i] >= dsh;
        assign rem_next = take ? rem_reg[i] - dsh : rem_reg[i];

        if (i == 0)
        begin : g_first
            assign q_next = QB'(take);
        end
        else
        begin : g_rest
            assign q_next = {q_reg[i][QB-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= rem_next;
                q_reg[i+1]   <= q_next;
                dq_reg[i+1]  <= dq_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    // remainder is below den here, so doubling it cannot overflow
    assign rnd     = {rem_reg[QB][RW-2:0], 1'b0} >= RW'(dq_reg[QB]);
    assign qf_next = (QB+1)'(q_reg[QB]) + (QB+1)'(rnd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qf_reg   <= qf_next;
            negc_reg <= neg_reg[QB];
            ovfc_reg <= ovf_reg[QB];
        end
    end

    assign over = ovfc_reg || (qf_reg > (negc_reg ? LIM_NEG : LIM_POS));
    assign qlo  = qf_reg[OW-1:0];

    always_comb
    begin
        if (over)
            quo_next = negc_reg ? W_MIN : W_MAX;
        else if (negc_reg)
            quo_next = weight_t'(-qlo);
        else
            quo_next = weight_t'(qlo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

### src/triangle_barycentric_coords_core.sv
`timescale 1ns / 1ps
// Barycentric weights of a query point against a triangle, fully pipelined.
// Depends on tbc_pkg, tbc_if, tbc_smul and tbc_div.
//
// Use:
//   query  : valid/ready sink. One transfer carries vertices A, B, C and point P,
//            each as three signed 16-bit integer coordinates.
//   result : valid/ready source. One transfer per query, in query order, carrying
//            weight_u, weight_v, weight_w (signed Q16.16, saturated) and degenerate.
//            A degenerate triangle (zero determinant) gives degenerate = 1 and all
//            weights zero.
// Path: a query passes the edge, dot product and determinant stages, then the
//   dividers, then 1 output register, before its result can transfer.
// Throughput: one query per cycle unless a stall freezes the pipeline. The divider
//   has 37 stages and resolves one quotient bit per step; it does not limit the rate.
// Stall: a skid register behind the output register catches the item leaving the
//   pipeline while the receiver holds off; only when the skid is full does the
//   pipeline freeze and query.ready drop. Nothing is lost or repeated.
// Reset: asynchronous, active low; clears all valid bits, so the pipeline and
//   output come up empty. No configuration and no state between queries.
module triangle_barycentric_coords_core (
    input  logic         clk,
    input  logic         rst_n,
    tbc_query_if.sink    query,
    tbc_result_if.source result
);
    import tbc_pkg::*;

    // pipeline advances unless the skid holds an item
    logic en;

    logic vld_reg [0:PIPE_DEPTH-1];
    logic dg_reg  [0:DIV_LAT-1];

    // stage 1: edge vectors B-A, C-A, P-A
    edge_t e0_next [3], e1_next [3], e2_next [3];
    edge_t e0_reg  [3], e1_reg  [3], e2_reg  [3];

    // stage 2: component products
    prod_t p00_reg [3], p01_reg [3], p11_reg [3], p20_reg [3], p21_reg [3];

    // stage 3: dot products
    dot_t d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;

    // stages 4-5: pair products
    wide_t m_den_a, m_den_b, m_nv_a, m_nv_b, m_nw_a, m_nw_b;

    // stage 6: determinant and numerators
    wide_t den_reg, nv_reg, nw_reg;
    logic  den_zero;

    // divider outputs, aligned with vld_reg[PIPE_DEPTH-1]
    weight_t v_q, w_q;

    // final combine
    logic signed [OW+1:0] u_full;
    weight_t              u_sat;
    res_t                 res_next;

    // output register and skid
    res_t out_data_reg, skid_data_reg;
    logic out_vld_reg, skid_vld_reg;
    logic take;

    assign en          = !skid_vld_reg;
    assign query.ready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= query.valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb
    begin
        e0_next[0] = EW'(query.vertex_b_x) - EW'(query.vertex_a_x);
        e0_next[1] = EW'(query.vertex_b_y) - EW'(query.vertex_a_y);
        e0_next[2] = EW'(query.vertex_b_z) - EW'(query.vertex_a_z);
        e1_next[0] = EW'(query.vertex_c_x) - EW'(query.vertex_a_x);
        e1_next[1] = EW'(query.vertex_c_y) - EW'(query.vertex_a_y);
        e1_next[2] = EW'(query.vertex_c_z) - EW'(query.vertex_a_z);
        e2_next[0] = EW'(query.point_x) - EW'(query.vertex_a_x);
        e2_next[1] = EW'(query.point_y) - EW'(query.vertex_a_y);
        e2_next[2] = EW'(query.point_z) - EW'(query.vertex_a_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e0_reg[k]  <= e0_next[k];
                e1_reg[k]  <= e1_next[k];
                e2_reg[k]  <= e2_next[k];
                p00_reg[k] <= e0_reg[k] * e0_reg[k];
                p01_reg[k] <= e0_reg[k] * e1_reg[k];
                p11_reg[k] <= e1_reg[k] * e1_reg[k];
                p20_reg[k] <= e2_reg[k] * e0_reg[k];
                p21_reg[k] <= e2_reg[k] * e1_reg[k];
            end
            d00_reg <= DW'(p00_reg[0]) + DW'(p00_reg[1]) + DW'(p00_reg[2]);
            d01_reg <= DW'(p01_reg[0]) + DW'(p01_reg[1]) + DW'(p01_reg[2]);
            d11_reg <= DW'(p11_reg[0]) + DW'(p11_reg[1]) + DW'(p11_reg[2]);
            d20_reg <= DW'(p20_reg[0]) + DW'(p20_reg[1]) + DW'(p20_reg[2]);
            d21_reg <= DW'(p21_reg[0]) + DW'(p21_reg[1]) + DW'(p21_reg[2]);
        end
    end

    tbc_smul u_mul_den_a (.clk(clk), .en(en), .a(d00_reg), .b(d11_reg), .p(m_den_a));
    tbc_smul u_mul_den_b (.clk(clk), .en(en), .a(d01_reg), .b(d01_reg), .p(m_den_b));
    tbc_smul u_mul_nv_a  (.clk(clk), .en(en), .a(d11_reg), .b(d20_reg), .p(m_nv_a));
    tbc_smul u_mul_nv_b  (.clk(clk), .en(en), .a(d01_reg), .b(d21_reg), .p(m_nv_b));
    tbc_smul u_mul_nw_a  (.clk(clk), .en(en), .a(d00_reg), .b(d21_reg), .p(m_nw_a));
    tbc_smul u_mul_nw_b  (.clk(clk), .en(en), .a(d01_reg), .b(d20_reg), .p(m_nw_b));

    // den = d00*d11 - d01^2 is never negative (Cauchy-Schwarz)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= m_den_a - m_den_b;
            nv_reg  <= m_nv_a - m_nv_b;
            nw_reg  <= m_nw_a - m_nw_b;
        end
    end

    assign den_zero = (den_reg == '0);

    tbc_div u_div_v (.clk(clk), .en(en), .num(nv_reg), .den(den_reg), .quo(v_q));
    tbc_div u_div_w (.clk(clk), .en(en), .num(nw_reg), .den(den_reg), .quo(w_q));

    // degenerate flag rides alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dg_reg[0] <= den_zero;
            for (int i = 1; i < DIV_LAT; i++)
                dg_reg[i] <= dg_reg[i-1];
        end
    end

    // u = 1 - v - w from the already rounded and saturated v, w
    assign u_full = (OW+2)'(ONE_Q) - (OW+2)'(v_q) - (OW+2)'(w_q);

    always_comb
    begin
        if (u_full > (OW+2)'(W_MAX))
            u_sat = W_MAX;
        else if (u_full < (OW+2)'(W_MIN))
            u_sat = W_MIN;
        else
            u_sat = u_full[OW-1:0];

        if (dg_reg[DIV_LAT-1])
        begin
            res_next.u          = '0;
            res_next.v          = '0;
            res_next.w          = '0;
            res_next.degenerate = 1'b1;
        end
        else
        begin
            res_next.u          = u_sat;
            res_next.v          = v_q;
            res_next.w          = w_q;
            res_next.degenerate = 1'b0;
        end
    end

    // output register with skid: the skid only fills when the output is stalled
    assign take = !out_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (result.ready)
                skid_vld_reg <= 1'b0;
        end
        else if (take)
            out_vld_reg <= vld_reg[PIPE_DEPTH-1];
        else if (vld_reg[PIPE_DEPTH-1])
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (result.ready)
                out_data_reg <= skid_data_reg;
        end
        else if (take)
            out_data_reg <= res_next;
        else
            skid_data_reg <= res_next;
    end

    assign result.valid      = out_vld_reg;
    assign result.weight_u   = out_data_reg.u;
    assign result.weight_v   = out_data_reg.v;
    assign result.weight_w   = out_data_reg.w;
    assign result.degenerate = out_data_reg.degenerate;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !result.ready && vld_reg[PIPE_DEPTH-1]))
        else $error("skid filled without a stalled output");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.degenerate) |->
            (result.weight_u == '0 && result.weight_v == '0 && result.weight_w == '0))
        else $error("degenerate result with nonzero weights");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for triangle_barycentric_coords_core: random and directed queries,
// scoreboard-checked weights. Depends on tbc_pkg, tbc_if and the core RTL.
module tb;
    import tbc_pkg::*;

    typedef coord_t query_t[12];

    // Scoreboard: predicts the weights of each accepted query in order and
    // compares them against the weights that come out of the core.
    class weight_scoreboard;
        res_t pending_weights[$];
        int   errors;

        function automatic weight_t round_q16(logic signed [127:0] num,
                                              logic [127:0] den);
            logic          neg;
            logic [127:0]  mag;
            logic [127:0]  q;
            logic [127:0]  r;
            neg = num < 0;
            mag = neg ? -num : num;
            mag = mag << FB;
            q = mag / den;
            r = mag - q * den;
            // round half away from zero
            if ((r << 1) >= den)
                q = q + 1;
            if (neg)
                return (q > 128'h8000_0000) ? W_MIN : weight_t'(-q);
            return (q > 128'h7FFF_FFFF) ? W_MAX : weight_t'(q);
        endfunction

        function automatic res_t predict_weights(query_t qry);
            longint             e0[3];
            longint             e1[3];
            longint             e2[3];
            logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw;
            longint             u_full;
            res_t               res;
            d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
            for (int k = 0; k < 3; k++)
            begin
                e0[k] = longint'(qry[3+k]) - longint'(qry[k]);
                e1[k] = longint'(qry[6+k]) - longint'(qry[k]);
                e2[k] = longint'(qry[9+k]) - longint'(qry[k]);
                d00 += e0[k] * e0[k];
                d01 += e0[k] * e1[k];
                d11 += e1[k] * e1[k];
                d20 += e2[k] * e0[k];
                d21 += e2[k] * e1[k];
            end
            den = d00 * d11 - d01 * d01;
            nv  = d11 * d20 - d01 * d21;
            nw  = d00 * d21 - d01 * d20;
            res = '0;
            if (den == 0)
            begin
                res.degenerate = 1'b1;
                return res;
            end
            res.v = round_q16(nv, den);
            res.w = round_q16(nw, den);
            u_full = longint'(ONE_Q) - longint'(res.v) - longint'(res.w);
            if (u_full > longint'(W_MAX))
                res.u = W_MAX;
            else if (u_full < longint'(W_MIN))
                res.u = W_MIN;
            else
                res.u = weight_t'(u_full);
            return res;
        endfunction

        function void note_query(query_t qry);
            pending_weights.push_back(predict_weights(qry));
        endfunction

        function void check_weights(res_t got);
            res_t exp_w;
            if (pending_weights.size() == 0)
            begin
                $display("%0t: unexpected result u=%0d v=%0d w=%0d deg=%0b",
                         $realtime, got.u, got.v, got.w, got.degenerate);
                errors++;
                return;
            end
            exp_w = pending_weights.pop_front();
            if (got.u !== exp_w.u)
            begin
                $display("%0t: weight_u expected %0d actual %0d", $realtime, exp_w.u, got.u);
                errors++;
            end
            if (got.v !== exp_w.v)
            begin
                $display("%0t: weight_v expected %0d actual %0d", $realtime, exp_w.v, got.v);
                errors++;
            end
            if (got.w !== exp_w.w)
            begin
                $display("%0t: weight_w expected %0d actual %0d", $realtime, exp_w.w, got.w);
                errors++;
            end
            if (got.degenerate !== exp_w.degenerate)
            begin
                $display("%0t: degenerate expected %0b actual %0b", $realtime,
                         exp_w.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    localparam int N_RANDOM   = 1530;
    localparam int HOLD_LEN   = 300;   // long receiver hold-off, fills the pipe
    localparam int IDLE_LIMIT = 2000;  // watchdog: cycles with no transfer

    logic clk;
    logic rst_n;

    tbc_query_if  query();
    tbc_result_if result();

    triangle_barycentric_coords_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    weight_scoreboard weights_sb;
    int               queries_sent;
    int               idle_cycles;
    logic             sending_done;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Drive one query and hold it until the core takes it.
    task automatic send_query(query_t qry);
        query.valid      <= 1'b1;
        query.vertex_a_x <= qry[0];
        query.vertex_a_y <= qry[1];
        query.vertex_a_z <= qry[2];
        query.vertex_b_x <= qry[3];
        query.vertex_b_y <= qry[4];
        query.vertex_b_z <= qry[5];
        query.vertex_c_x <= qry[6];
        query.vertex_c_y <= qry[7];
        query.vertex_c_z <= qry[8];
        query.point_x    <= qry[9];
        query.point_y    <= qry[10];
        query.point_z    <= qry[11];
        do
            @(posedge clk);
        while (!query.ready);
        weights_sb.note_query(qry);
        queries_sent++;
    endtask

    task automatic idle_sender(int cycles);
        query.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int span);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return coord_t'(-32768);
            1: return coord_t'(32767);
            2: return coord_t'(0);
            3: return coord_t'(-1);
            default: return coord_t'(1);
        endcase
    endfunction

    // Random query: mostly sound triangles of mixed scale, plus degenerate
    // shapes, extreme coordinates and far-off points that drive saturation.
    function automatic query_t rand_query();
        query_t qry;
        int     span;
        int     k;
        coord_t dir[3];
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                foreach (qry[i]) qry[i] = coord_t'($urandom());
            end
            3, 4, 5:
            begin
                case ($urandom_range(0, 2))
                    0: span = 4;
                    1: span = 100;
                    default: span = 2000;
                endcase
                foreach (qry[i]) qry[i] = rand_coord(span);
            end
            6:
            begin
                // collinear: C = A + k * (B - A)
                k = $urandom_range(0, 20) - 10;
                for (int j = 0; j < 3; j++)
                begin
                    qry[j]   = rand_coord(1000);
                    dir[j]   = rand_coord(50);
                    qry[3+j] = qry[j] + dir[j];
                    qry[6+j] = qry[j] + coord_t'(k) * dir[j];
                    qry[9+j] = rand_coord(32767);
                end
            end
            7:
            begin
                // two coincident vertices
                foreach (qry[i]) qry[i] = coord_t'($urandom());
                for (int j = 0; j < 3; j++)
                    if ($urandom_range(0, 1))
                        qry[3+j] = qry[j];
                    else
                        qry[6+j] = qry[3+j];
                if (qry[3] != qry[0] || qry[4] != qry[1] || qry[5] != qry[2])
                    for (int j = 0; j < 3; j++) qry[6+j] = qry[3+j];
            end
            8:
            begin
                // tiny triangle, point far away
                foreach (qry[i]) qry[i] = rand_coord(3);
                for (int j = 9; j < 12; j++) qry[j] = pick_extreme();
            end
            default:
            begin
                foreach (qry[i]) qry[i] = pick_extreme();
            end
        endcase
        return qry;
    endfunction

    function automatic query_t make_query(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz, int px, int py, int pz);
        query_t qry;
        qry = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
                coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(px),
                coord_t'(py), coord_t'(pz)};
        return qry;
    endfunction

    // Sender: directed cases, then random queries in bursts with gaps.
    initial
    begin
        query_t qry;
        int     burst;
        weights_sb   = new();
        queries_sent = 0;
        sending_done = 1'b0;
        rst_n        <= 1'b0;
        query.valid  <= 1'b0;
        foreach (qry[i]) qry[i] = '0;
        query.vertex_a_x <= '0; query.vertex_a_y <= '0; query.vertex_a_z <= '0;
        query.vertex_b_x <= '0; query.vertex_b_y <= '0; query.vertex_b_z <= '0;
        query.vertex_c_x <= '0; query.vertex_c_y <= '0; query.vertex_c_z <= '0;
        query.point_x    <= '0; query.point_y    <= '0; query.point_z    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all zero: coincident vertices
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // right triangle, point at each vertex, centroid-ish, midpoint
        send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 0, 0));
        send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 4, 0, 0));
        send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 4, 0));
        send_query(make_query(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0));
        send_query(make_query(0, 0, 0, 2, 0, 0, 0, 2, 0, 1, 1, 7));
        // rounding: thirds, and a point outside the triangle
        send_query(make_query(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 2, 0));
        send_query(make_query(0, 0, 0, 65535 & 0, 1, 0, 1, 0, 0, -1, -1, 0));
        // collinear and coincident
        send_query(make_query(0, 0, 0, 1, 1, 1, 2, 2, 2, 5, -3, 9));
        send_query(make_query(5, 5, 5, 5, 5, 5, 9, 1, -4, 0, 0, 0));
        send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                              0, 0, 0, 1, 2, 3));
        // extreme coordinates, full span edges
        send_query(make_query(-32768, -32768, -32768, 32767, -32768, -32768,
                              -32768, 32767, -32768, 32767, 32767, 32767));
        send_query(make_query(32767, 32767, 32767, -32768, 32767, 32767,
                              32767, -32768, 32767, -32768, -32768, -32768));
        send_query(make_query(-32768, 32767, -32768, 32767, -32768, 32767,
                              -32768, -32768, 32767, 0, 0, 0));
        // tiny triangle, far-off points: positive and negative saturation
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 0));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, -32768, -32768));
        send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 32767, 32767));
        // slim triangle, large determinant ratios
        send_query(make_query(0, 0, 0, 32767, 0, 0, 32767, 1, 0, -32768, 32767, 0));

        // random part: bursts of back-to-back queries, most followed by a gap
        while (queries_sent < N_RANDOM + 19)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                qry = rand_query();
                send_query(qry);
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
        query.valid  <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: own stall pattern, runs of ready and runs of stall, plus one
    // long hold-off once traffic is flowing so the core backs up its input.
    initial
    begin
        logic hold_done;
        int   run;
        hold_done    = 1'b0;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && queries_sent > 300)
            begin
                hold_done = 1'b1;
                result.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            run = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0:
                begin
                    result.ready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
                1:
                begin
                    // alternate ready every cycle
                    repeat (run)
                    begin
                        result.ready <= ~result.ready;
                        @(posedge clk);
                    end
                end
                default:
                begin
                    result.ready <= 1'b1;
                    repeat (run) @(posedge clk);
                end
            endcase
        end
    end

    // Result monitor: every transfer on the result side goes to the scoreboard.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got.u          = result.weight_u;
            got.v          = result.weight_v;
            got.w          = result.weight_w;
            got.degenerate = result.degenerate;
            weights_sb.check_weights(got);
        end
    end

    // Watchdog: counts cycles without a transfer on either channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((query.valid && query.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End of run: drain, allow the pipeline latency for stray results, report.
    initial
    begin
        wait (sending_done);
        while (weights_sb.pending_weights.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (weights_sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
